[rtl/core/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the spi master pin sequencer
// Command codes, the pin-state word layout and the command beat carried from
// the front end to the sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

   // command codes as they arrive on req_type
   localparam logic [2:0] CMD_INIT  = 3'd0;
   localparam logic [2:0] CMD_BEGIN = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_END   = 3'd4;

   // clock pulses given by begin with chip select still high
   localparam int RESET_CLOCK_PULSES_DEF = 2;

   // command queue between front end and sequencer
   localparam int QUEUE_DEPTH = 2;

   // word counter within one command
   localparam int PHASE_W = 5;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic [7:0] miso_bits;
   } cmd_type;

   // head of the command queue as seen by the sequencer
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic mosi;
      logic sclk;
      logic cs;
   } pins_type;

   // parked pins: chip select high, clock and data low
   localparam pins_type PINS_PARK = '{mosi: 1'b0, sclk: 1'b0, cs: 1'b1};

endpackage

[rtl/core/spi_master_pin_sequencer.sv]
// ----------------------------------------------------------------------------
// spi_master_pin_sequencer: spi mode 0 master as a pin-state word generator
// Turns init, begin, write byte, read byte and end commands into MOSI, SCLK
// and chip select words, msb first, with the read byte on the last word.
// ----------------------------------------------------------------------------
// Commands enter a two-deep queue at one beat per cycle while it has room;
// unused codes are taken and dropped. The sequencer loads one command only
// once it is done with the last, then emits one pin-state word per cycle,
// unless a full output register stalls it, which happens only while the
// consumer holds off pop.
module spi_master_pin_sequencer #(
   parameter int RESET_CLOCK_PULSES = sps_pkg::RESET_CLOCK_PULSES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_type,
   input  logic [7:0] req_tx_byte,
   input  logic [7:0] req_miso_bits,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_mosi,
   output logic       rsp_sclk,
   output logic       rsp_cs_level,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_last
);
   import sps_pkg::*;

   cmd_head_type cmd_head;
   logic         cmd_pop;

   sps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_type      (req_type),
      .req_tx_byte   (req_tx_byte),
      .req_miso_bits (req_miso_bits),
      .cmd_head      (cmd_head),
      .cmd_pop       (cmd_pop)
   );

   sps_back #(
      .RESET_CLOCK_PULSES (RESET_CLOCK_PULSES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_head     (cmd_head),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_mosi     (rsp_mosi),
      .rsp_sclk     (rsp_sclk),
      .rsp_cs_level (rsp_cs_level),
      .rsp_rx_byte  (rsp_rx_byte),
      .rsp_last     (rsp_last)
   );

   // read byte shows only on the last word of a command
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_rx_byte != 8'd0)) |-> rsp_last)
      else $error("rx byte on a word that is not last");

   // no command ends with the clock high
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> !rsp_sclk)
      else $error("command ended with sclk high");

   // sequencer takes a command only from a filled queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_head.valid)
      else $error("command popped from empty queue");

endmodule

[rtl/core/sps_front.sv]
// ----------------------------------------------------------------------------
// sps_front: command intake
// Takes request beats, drops unused codes and keeps the valid commands in a
// short queue that the sequencer drains at its own pace.
// ----------------------------------------------------------------------------
module sps_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [2:0]            req_type,
   input  logic [7:0]            req_tx_byte,
   input  logic [7:0]            req_miso_bits,
   output sps_pkg::cmd_head_type cmd_head,
   input  logic                  cmd_pop
);
   import sps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            queue_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               code_known;
   logic               accept;
   logic               push;
   logic               pop;

   // classify the request code
   assign code_known = (req_type == CMD_INIT) || (req_type == CMD_BEGIN) ||
                       (req_type == CMD_WRITE) || (req_type == CMD_READ) ||
                       (req_type == CMD_END);

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign push     = accept && code_known;
   assign pop      = cmd_pop && (count_ff != '0);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= '{kind: req_type, tx_byte: req_tx_byte,
                                   miso_bits: req_miso_bits};
      end
   end

   assign cmd_head.valid = (count_ff != '0);
   assign cmd_head.cmd   = queue_mem[rd_ptr_ff];

endmodule

[rtl/core/sps_back.sv]
// ----------------------------------------------------------------------------
// sps_back: pin-state sequencer
// Loads one command from the queue and steps through its pin-state words,
// one word per cycle into an output register that the consumer pops, unless it is full and not popped.
// ----------------------------------------------------------------------------
module sps_back #(
   parameter int RESET_CLOCK_PULSES = sps_pkg::RESET_CLOCK_PULSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sps_pkg::cmd_head_type cmd_head,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_mosi,
   output logic                  rsp_sclk,
   output logic                  rsp_cs_level,
   output logic [7:0]            rsp_rx_byte,
   output logic                  rsp_last
);
   import sps_pkg::*;

   localparam logic [PHASE_W-1:0] BEGIN_LAST = PHASE_W'(2 * RESET_CLOCK_PULSES);

   logic               busy_ff, busy_in;
   cmd_type            cmd_ff, cmd_in;
   pins_type           pins_ff, pins_in;
   logic [7:0]         shift_ff, shift_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [1:0]         sub_ff, sub_in;
   logic [2:0]         bit_ff, bit_in;
   logic               out_valid_ff, out_valid_in;
   pins_type           out_pins_ff, out_pins_in;
   logic [7:0]         out_rx_ff, out_rx_in;
   logic               out_last_ff, out_last_in;

   pins_type           word_pins;
   logic [7:0]         word_rx;
   logic               word_last;
   logic               advance;

   assign advance = busy_ff && (!out_valid_ff || rsp_pop);
   assign cmd_pop = !busy_ff && cmd_head.valid;

   // pin-state word for the current phase
   always_comb begin
      word_pins = pins_ff;
      word_rx   = 8'd0;
      word_last = 1'b0;
      shift_in  = shift_ff;
      sub_in    = sub_ff;
      bit_in    = bit_ff;
      unique case (cmd_ff.kind)
         CMD_INIT: begin
            word_pins = PINS_PARK;
            word_last = 1'b1;
         end
         CMD_BEGIN: begin
            if (phase_ff == BEGIN_LAST) begin
               word_pins.cs = 1'b0;
               word_last    = 1'b1;
            end else begin
               word_pins.sclk = ~phase_ff[0];
            end
         end
         CMD_WRITE: begin
            unique case (sub_ff)
               2'd0: begin
                  word_pins.mosi = shift_ff[7];
                  sub_in         = 2'd1;
               end
               2'd1: begin
                  word_pins.sclk = 1'b1;
                  sub_in         = 2'd2;
               end
               2'd2: begin
                  word_pins.sclk = 1'b0;
                  word_last      = (bit_ff == 3'd7);
                  shift_in       = {shift_ff[6:0], 1'b0};
                  sub_in         = 2'd0;
                  bit_in         = bit_ff + 1'b1;
               end
               default: begin
                  sub_in = 2'd0;
               end
            endcase
         end
         CMD_READ: begin
            if (sub_ff == 2'd0) begin
               // clock high, sample miso msb first
               word_pins.mosi = 1'b0;
               word_pins.sclk = 1'b1;
               shift_in       = {shift_ff[6:0], cmd_ff.miso_bits[~bit_ff]};
               sub_in         = 2'd1;
            end else begin
               word_pins.sclk = 1'b0;
               word_last      = (bit_ff == 3'd7);
               word_rx        = word_last ? shift_ff : 8'd0;
               sub_in         = 2'd0;
               bit_in         = bit_ff + 1'b1;
            end
         end
         CMD_END: begin
            word_pins.cs = 1'b1;
            word_last    = 1'b1;
         end
         default: begin
            word_last = 1'b1;
         end
      endcase
   end

   // sequencer state
   always_comb begin
      busy_in  = busy_ff;
      cmd_in   = cmd_ff;
      pins_in  = pins_ff;
      phase_in = phase_ff;
      if (cmd_pop) begin
         busy_in  = 1'b1;
         cmd_in   = cmd_head.cmd;
         phase_in = '0;
      end else if (advance) begin
         pins_in  = word_pins;
         phase_in = phase_ff + 1'b1;
         if (word_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pins_ff  <= PINS_PARK;
         shift_ff <= 8'd0;
         phase_ff <= '0;
         sub_ff   <= 2'd0;
         bit_ff   <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         pins_ff  <= pins_in;
         phase_ff <= phase_in;
         if (cmd_pop) begin
            shift_ff <= (cmd_head.cmd.kind == CMD_WRITE) ? cmd_head.cmd.tx_byte : 8'd0;
            sub_ff   <= 2'd0;
            bit_ff   <= 3'd0;
         end else if (advance) begin
            shift_ff <= shift_in;
            sub_ff   <= sub_in;
            bit_ff   <= bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pins_in  = out_pins_ff;
      out_rx_in    = out_rx_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_pins_in  = word_pins;
         out_rx_in    = word_rx;
         out_last_in  = word_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pins_ff <= out_pins_in;
      out_rx_ff   <= out_rx_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_mosi     = out_pins_ff.mosi;
   assign rsp_sclk     = out_pins_ff.sclk;
   assign rsp_cs_level = out_pins_ff.cs;
   assign rsp_rx_byte  = out_rx_ff;
   assign rsp_last     = out_last_ff;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the spi master pin sequencer
// Sends init, begin, write, read and end commands plus unused codes, predicts
// every pin-state word in a local sequencer model, and compares each word
// popped from the block field by field. Both sides idle at random, and the
// receiver stalls for a long stretch once to fill the block.
// ----------------------------------------------------------------------------
module tb_top;
   import sps_pkg::*;

   // request codes that the block takes and drops
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int MAX_IDLE        = 17;
   localparam int RANDOM_CMDS     = 70;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic       mosi;
      logic       sclk;
      logic       cs;
      logic [7:0] rx_byte;
      logic       last;
   } pin_word_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_type = CMD_INIT;
   logic [7:0] req_tx_byte = 8'h00;
   logic [7:0] req_miso_bits = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_mosi;
   logic       rsp_sclk;
   logic       rsp_cs_level;
   logic [7:0] rsp_rx_byte;
   logic       rsp_last;

   // predicted pin words, oldest first, and the pin state behind them
   pin_word_type pending_words[$];
   pins_type     model_pins = PINS_PARK;

   // idling controls shared by the tests and the two sides
   bit         tx_idle_on = 1'b1;
   bit         rx_idle_on = 1'b1;
   int         rx_hold_req = 0;

   int         n_errors = 0;
   int         n_cmds = 0;
   int         n_ignored = 0;
   int         n_words = 0;
   int         idle_cycles = 0;

   spi_master_pin_sequencer u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_type     (req_type),
      .req_tx_byte  (req_tx_byte),
      .req_miso_bits(req_miso_bits),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_mosi     (rsp_mosi),
      .rsp_sclk     (rsp_sclk),
      .rsp_cs_level (rsp_cs_level),
      .rsp_rx_byte  (rsp_rx_byte),
      .rsp_last     (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // append one word built from the current model pins
   function automatic void add_pin_word(logic [7:0] rx, logic is_last);
      pin_word_type w;
      w.mosi    = model_pins.mosi;
      w.sclk    = model_pins.sclk;
      w.cs      = model_pins.cs;
      w.rx_byte = is_last ? rx : 8'h00;
      w.last    = is_last;
      pending_words.push_back(w);
   endfunction

   // expected pin sequence of one accepted command
   function automatic void sequence_pins(logic [2:0] kind, logic [7:0] tx, logic [7:0] miso);
      logic [7:0] shreg;
      unique case (kind)
         CMD_INIT: begin
            model_pins = PINS_PARK;
            add_pin_word(8'h00, 1'b1);
         end
         CMD_BEGIN: begin
            for (int k = 0; k < RESET_CLOCK_PULSES_DEF; k++) begin
               model_pins.sclk = 1'b1;
               add_pin_word(8'h00, 1'b0);
               model_pins.sclk = 1'b0;
               add_pin_word(8'h00, 1'b0);
            end
            model_pins.cs = 1'b0;
            add_pin_word(8'h00, 1'b1);
         end
         CMD_WRITE: begin
            shreg = tx;
            for (int k = 0; k < 8; k++) begin
               model_pins.mosi = shreg[7];
               add_pin_word(8'h00, 1'b0);
               model_pins.sclk = 1'b1;
               add_pin_word(8'h00, 1'b0);
               model_pins.sclk = 1'b0;
               add_pin_word(8'h00, k == 7);
               shreg = {shreg[6:0], 1'b0};
            end
         end
         CMD_READ: begin
            // data line forced low, miso sampled msb first on clock high
            model_pins.mosi = 1'b0;
            shreg = 8'h00;
            for (int k = 0; k < 8; k++) begin
               model_pins.sclk = 1'b1;
               shreg = {shreg[6:0], miso[7-k]};
               add_pin_word(8'h00, 1'b0);
               model_pins.sclk = 1'b0;
               add_pin_word(shreg, k == 7);
            end
         end
         CMD_END: begin
            model_pins.cs = 1'b1;
            add_pin_word(8'h00, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // offer one command beat, wait for it to be taken, then predict its words
   task automatic send_cmd(logic [2:0] kind, logic [7:0] tx, logic [7:0] miso);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_type      <= kind;
      req_tx_byte   <= tx;
      req_miso_bits <= miso;
      do @(posedge clock); while (req_full);
      sequence_pins(kind, tx, miso);
      if (kind >= CMD_UNUSED_FIRST)
         n_ignored++;
      else
         n_cmds++;
   endtask

   // stop offering and wait until every predicted word has been popped
   task automatic wait_drain();
      req_push <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(string name, logic [7:0] expected, logic [7:0] actual);
      if (expected !== actual) begin
         $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
         n_errors++;
      end
   endtask

   // result side: random pop gaps, one long hold on request
   initial begin
      pin_word_type w;
      int gap;
      wait (!reset);
      forever begin
         if (rx_hold_req > 0) begin
            gap = rx_hold_req;
            rx_hold_req = 0;
         end else begin
            gap = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (pending_words.size() == 0) begin
            $error("pin-state word with none expected: mosi %0b sclk %0b cs %0b rx %0h last %0b",
                   rsp_mosi, rsp_sclk, rsp_cs_level, rsp_rx_byte, rsp_last);
            n_errors++;
         end else begin
            w = pending_words.pop_front();
            check_field("mosi", 8'(w.mosi), 8'(rsp_mosi));
            check_field("sclk", 8'(w.sclk), 8'(rsp_sclk));
            check_field("cs_level", 8'(w.cs), 8'(rsp_cs_level));
            check_field("rx_byte", w.rx_byte, rsp_rx_byte);
            check_field("last", 8'(w.last), 8'(rsp_last));
            n_words++;
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no beat for %0d cycles, %0d words outstanding",
                   WATCHDOG_LIMIT, pending_words.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // full transfer with data extremes on write and read
   task automatic test_basic_transfer();
      send_cmd(CMD_INIT, 8'h00, 8'h00);
      send_cmd(CMD_BEGIN, 8'hFF, 8'hFF);
      send_cmd(CMD_WRITE, 8'h00, 8'hFF);
      send_cmd(CMD_WRITE, 8'hFF, 8'h00);
      send_cmd(CMD_WRITE, 8'hA5, 8'h00);
      send_cmd(CMD_READ, 8'hFF, 8'h00);
      send_cmd(CMD_READ, 8'h00, 8'hFF);
      send_cmd(CMD_READ, 8'h00, 8'h5A);
      send_cmd(CMD_END, 8'h00, 8'h00);
   endtask

   // commands out of order run from whatever pin state is current
   task automatic test_out_of_order();
      send_cmd(CMD_END, 8'h00, 8'h00);
      send_cmd(CMD_WRITE, 8'h81, 8'h00);
      send_cmd(CMD_READ, 8'h00, 8'hC3);
      send_cmd(CMD_BEGIN, 8'h00, 8'h00);
      send_cmd(CMD_BEGIN, 8'h00, 8'h00);
      // leave mosi high, then begin pulses and a read that pulls it low
      send_cmd(CMD_WRITE, 8'h01, 8'h00);
      send_cmd(CMD_BEGIN, 8'h00, 8'h00);
      send_cmd(CMD_READ, 8'h00, 8'h00);
      send_cmd(CMD_END, 8'h00, 8'h00);
      send_cmd(CMD_END, 8'h00, 8'h00);
      send_cmd(CMD_INIT, 8'h00, 8'h00);
   endtask

   // unused request codes give no words and leave the pins alone
   task automatic test_unused_codes();
      send_cmd(CMD_UNUSED_FIRST, 8'hFF, 8'hFF);
      send_cmd(CMD_UNUSED_MID, 8'h00, 8'h00);
      send_cmd(CMD_UNUSED_LAST, 8'h3C, 8'hC3);
      send_cmd(CMD_END, 8'h00, 8'h00);
   endtask

   // receiver stalls long while the sender keeps pushing writes
   task automatic test_receiver_hold();
      tx_idle_on  = 1'b0;
      rx_hold_req = HOLD_CYCLES;
      send_cmd(CMD_BEGIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      for (int i = 0; i < 4; i++)
         send_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_cmd(CMD_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      tx_idle_on = 1'b1;
   endtask

   // mostly well-formed transfers with random bytes, some noise
   task automatic test_random_transfers();
      int goal;
      int n_bytes;
      int pick;
      goal = n_cmds + RANDOM_CMDS;
      while (n_cmds < goal) begin
         // stretches with and without idling on each side
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_cmd(CMD_BEGIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            n_bytes = $urandom_range(1, 4);
            for (int i = 0; i < n_bytes; i++)
               send_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_cmd(CMD_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (pick == 7) begin
            send_cmd(CMD_INIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (pick == 8) begin
            send_cmd(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            send_cmd(3'($urandom_range(CMD_INIT, CMD_END)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // sequence of tests
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_transfer();
      wait_drain();
      test_out_of_order();
      test_unused_codes();
      wait_drain();
      test_receiver_hold();
      wait_drain();
      test_random_transfers();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d commands and %0d unused codes, checked %0d pin-state words",
               n_cmds, n_ignored, n_words);
      $display("covered in and out of order transfers, long receiver stall, random idling");
      if (n_errors == 0 && pending_words.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sps_pkg.sv
rtl/core/sps_front.sv
rtl/core/sps_back.sv
rtl/core/spi_master_pin_sequencer.sv
sim/tb_top.sv
